>>> hw/rtl/esd_pkg.sv
`default_nettype none

package esd_pkg;

	// decoder modes
	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_OCT   = 2'd2,
		MODE_HEX   = 2'd3
	} mode_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_SEVEN  = 8'h37;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_X      = 8'h78;

	localparam logic [1:0] OCT_DIGITS = 2'd3;
	localparam logic [1:0] HEX_DIGITS = 2'd2;

	// output queue depth and derived widths
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	// one input beat after the input register
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} item_t;

	// up to two result bytes from one input beat
	typedef struct packed {
		logic [1:0] n;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} res_t;

	// one queued result beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} beat_t;

	// hex digit value, valid flag in the top bit
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= CH_ZERO && b <= CH_NINE) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, 4'(b[3:0] + 4'd9)};
		end
		return r;
	endfunction

	// simple escape letters, valid flag in the top bit
	function automatic logic [8:0] simple_escape(input logic [7:0] b);
		logic [8:0] r;
		case (b)
			8'h61: r = {1'b1, 8'h07};
			8'h62: r = {1'b1, 8'h08};
			8'h74: r = {1'b1, 8'h09};
			8'h6E: r = {1'b1, 8'h0A};
			8'h76: r = {1'b1, 8'h0B};
			8'h66: r = {1'b1, 8'h0C};
			8'h72: r = {1'b1, 8'h0D};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_QUOTE: r = {1'b1, CH_QUOTE};
			CH_DQUOTE: r = {1'b1, CH_DQUOTE};
			default: r = {1'b0, b};
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/esd_decode.sv
`default_nettype none

module esd_decode (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire esd_pkg::item_t item,
	output esd_pkg::res_t       res
);
	import esd_pkg::*;

	mode_t      mode_q, mode_d;
	logic [1:0] cnt_q, cnt_d;
	logic [7:0] acc_q, acc_d;

	logic [7:0] b;
	logic [4:0] hd;
	logic [8:0] se;
	logic [1:0] cnt_inc;
	logic [7:0] oct_acc;
	logic [7:0] hex_acc;
	logic       is_oct;

	assign b       = item.in_byte;
	assign hd      = hex_digit(b);
	assign se      = simple_escape(b);
	assign cnt_inc = cnt_q + 2'd1;
	assign oct_acc = {acc_q[4:0], b[2:0]};
	assign hex_acc = {acc_q[3:0], hd[3:0]};
	assign is_oct  = (b >= CH_ZERO) && (b <= CH_SEVEN);

	// next state and results for the beat in the input register
	always_comb begin
		mode_d    = mode_q;
		cnt_d     = cnt_q;
		acc_d     = acc_q;
		res.n     = 2'd0;
		res.byte0 = acc_q;
		res.byte1 = b;
		if (item.end_of_stream) begin
			mode_d = MODE_PLAIN;
			cnt_d  = 2'd0;
			acc_d  = 8'd0;
			unique case (mode_q)
				MODE_PLAIN: res.n = 2'd0;
				MODE_ESC: begin
					res.n     = 2'd1;
					res.byte0 = CH_BSLASH;
				end
				MODE_OCT, MODE_HEX: res.n = 2'd1;
				default: res.n = 2'd0;
			endcase
		end else begin
			unique case (mode_q)
				MODE_PLAIN: begin
					if (b == CH_BSLASH) begin
						mode_d = MODE_ESC;
					end else begin
						res.n     = 2'd1;
						res.byte0 = b;
					end
				end
				MODE_ESC: begin
					if (b == CH_ZERO || b == CH_ONE) begin
						mode_d = MODE_OCT;
						acc_d  = {7'd0, b[0]};
						cnt_d  = 2'd1;
					end else if (b == CH_X) begin
						mode_d = MODE_HEX;
						acc_d  = 8'd0;
						cnt_d  = 2'd0;
					end else begin
						mode_d = MODE_PLAIN;
						acc_d  = 8'd0;
						cnt_d  = 2'd0;
						if (se[8]) begin
							res.n     = 2'd1;
							res.byte0 = se[7:0];
						end else begin
							res.n     = 2'd2;
							res.byte0 = CH_BSLASH;
						end
					end
				end
				MODE_OCT, MODE_HEX: begin
					if ((mode_q == MODE_OCT && is_oct) || (mode_q == MODE_HEX && hd[4])) begin
						acc_d = (mode_q == MODE_OCT) ? oct_acc : hex_acc;
						cnt_d = cnt_inc;
						// digit limit reached: emit now
						if ((mode_q == MODE_OCT && cnt_inc == OCT_DIGITS) ||
						    (mode_q == MODE_HEX && cnt_inc == HEX_DIGITS)) begin
							res.n     = 2'd1;
							res.byte0 = acc_d;
							mode_d    = MODE_PLAIN;
							cnt_d     = 2'd0;
							acc_d     = 8'd0;
						end
					end else begin
						// non-digit closes the value, then is taken as plain
						cnt_d = 2'd0;
						acc_d = 8'd0;
						if (b == CH_BSLASH) begin
							mode_d = MODE_ESC;
							res.n  = 2'd1;
						end else begin
							mode_d = MODE_PLAIN;
							res.n  = 2'd2;
						end
					end
				end
				default: mode_d = MODE_PLAIN;
			endcase
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_PLAIN;
			cnt_q  <= 2'd0;
			acc_q  <= 8'd0;
		end else if (en) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/esd_outq.sv
`default_nettype none

module esd_outq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire esd_pkg::res_t          res,
	output logic                       room,
	output logic                       valid,
	input  wire logic                  ready,
	output esd_pkg::beat_t              head
);
	import esd_pkg::*;

	beat_t            mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;
	logic [QPtrW-1:0] wr_ptr_1;
	logic [1:0]       n_push;
	logic             pop;

	assign n_push   = push ? res.n : 2'd0;
	assign pop      = valid && ready;
	assign wr_ptr_1 = wr_ptr_q + QPtrW'(1);
	assign valid    = (cnt_q != '0);
	assign room     = (cnt_q <= QCntW'(QDepth - 2));
	assign head     = mem_q[rd_ptr_q];

	// result storage, one or two beats written per cycle
	always_ff @(posedge clk) begin
		if (n_push == 2'd1) begin
			mem_q[wr_ptr_q] <= '{out_byte: res.byte0, last: 1'b1};
		end else if (n_push == 2'd2) begin
			mem_q[wr_ptr_q] <= '{out_byte: res.byte0, last: 1'b0};
			mem_q[wr_ptr_1] <= '{out_byte: res.byte1, last: 1'b1};
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPtrW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			cnt_q <= cnt_q + QCntW'(n_push) - QCntW'(pop);
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/escape_sequence_decoder_core.sv
// C-style escape decoder on a byte stream. Each input beat carries one raw byte in
// s_axis_tdata; s_axis_tlast marks end of stream, flushes any pending escape and its
// byte is ignored. One input beat yields zero, one or two output beats, and
// m_axis_tlast is set on the final output beat of each input beat. Beats are taken one
// per clock: an input register feeds the decoder, whose combinational results go to a
// four-entry output queue. The input side stalls only while that queue holds more
// than two beats, so sustained input rate is one byte per cycle whenever the output
// side keeps up; each input beat is registered at the input and then in the queue.
`default_nettype none

module escape_sequence_decoder_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  wire logic       s_axis_tlast,   // end_of_stream
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
	output logic            m_axis_tlast    // last
);
	import esd_pkg::*;

	item_t item_s1;
	logic  valid_s1;
	logic  room;
	logic  advance;
	res_t  res;
	beat_t head;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	// input register, payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= '{in_byte: s_axis_tdata, end_of_stream: s_axis_tlast};
		end
	end

	// input register, valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	esd_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.res    (res)
	);

	esd_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance),
		.res    (res),
		.room   (room),
		.valid  (m_axis_tvalid),
		.ready  (m_axis_tready),
		.head   (head)
	);

	assign m_axis_tdata = head.out_byte;
	assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

>>> hw/rtl/esd_checker.sv
`default_nettype none

module esd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic [7:0] s_axis_tdata,
	input wire logic       s_axis_tlast,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast
);

	// a stalled output beat keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// input back pressure only when results are waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// output from an empty queue comes from a beat taken through the input register, then queued
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("output appeared without matching input beat");

	// a stalled input beat is held until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
		else $error("input beat changed while stalled");

endmodule

bind escape_sequence_decoder_core esd_checker u_esd_checker (.*);

`default_nettype wire
